/* design/ahds_pkg.sv */
// ----------------------------------------------------------------------------
// ahds_pkg
// Shared types and constants for the halving/doubling allreduce scheduler.
// ----------------------------------------------------------------------------
package ahds_pkg;

  localparam int unsigned MAX_RANKS_DEF = 1024;

  localparam int unsigned RANK_W  = 10;
  localparam int unsigned COUNT_W = 11;
  localparam int unsigned CHUNK_W = 32;
  localparam int unsigned TOTAL_W = CHUNK_W + COUNT_W;
  localparam int unsigned BYTES_W = 42;
  localparam int unsigned STEP_W  = 5;
  localparam int unsigned LG_W    = 4;
  localparam int unsigned CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_RANK_COUNT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CHUNK_SIZE = 2'd1;

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_FOLD_X,
    PH_FOLD_Y,
    PH_HALVE,
    PH_DOUBLE,
    PH_UNFOLD
  } phase_t;

  typedef struct packed {
    logic [RANK_W-1:0]  rank;
    logic [RANK_W-1:0]  q;
    logic               sit;
    logic               low;
    logic               fold;
    logic [LG_W-1:0]    lg;
    logic [RANK_W-1:0]  r;
    logic [TOTAL_W-1:0] total;
  } ctx_t;

endpackage

/* design/ahds_ifs.sv */
// ----------------------------------------------------------------------------
// ahds channel interfaces
// Request, step result and register write channels with valid/ready.
// ----------------------------------------------------------------------------
interface ahds_req_if;
  logic                       valid;
  logic                       ready;
  logic [ahds_pkg::RANK_W-1:0] rank;

  modport source (output valid, output rank, input ready);
  modport sink (input valid, input rank, output ready);
endinterface

interface ahds_step_if;
  logic                         valid;
  logic                         ready;
  logic [ahds_pkg::STEP_W-1:0]  step_index;
  logic                         recv_valid;
  logic [ahds_pkg::RANK_W-1:0]  recv_peer;
  logic                         send_valid;
  logic [ahds_pkg::RANK_W-1:0]  send_peer;
  logic [ahds_pkg::BYTES_W-1:0] byte_count;
  logic                         last;

  modport source (output valid, output step_index, output recv_valid, output recv_peer,
                  output send_valid, output send_peer, output byte_count, output last,
                  input ready);
  modport sink (input valid, input step_index, input recv_valid, input recv_peer,
                input send_valid, input send_peer, input byte_count, input last,
                output ready);
endinterface

interface ahds_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [ahds_pkg::CFG_IDX_W-1:0] index;
  logic [ahds_pkg::CHUNK_W-1:0]   data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

/* design/allreduce_halving_doubling_schedule.sv */
// ----------------------------------------------------------------------------
// allreduce_halving_doubling_schedule
// Emits one rank's recursive halving/doubling allreduce schedule, one step
// per result, with fold and unfold steps for non-power-of-two rank counts.
//
//   channel  dir  payload
//   cfg      in   index, data       register write, always ready
//   req      in   rank              schedule request
//   steps    out  step_index .. last one schedule step
//
// A request passes through the front pipeline, then the sequencer emits
// 2*log2(pw) steps, plus 3 more when rank_count is not a power of two,
// one per cycle unless stalled (at most 21); it sets the sustained rate.
// Requests overlap: the next one is folded while the current one streams.
// Reset is synchronous and clears all valid bits and the sequencer phase.
// A stall on steps holds the output register and backs up the pipeline.
// ----------------------------------------------------------------------------
module allreduce_halving_doubling_schedule import ahds_pkg::*; #(
  parameter int unsigned MAX_RANKS = MAX_RANKS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  ahds_cfg_if.sink    cfg,
  ahds_req_if.sink    req,
  ahds_step_if.source steps
);

  logic [COUNT_W-1:0] rank_count;
  logic [CHUNK_W-1:0] chunk_size;
  logic               ctx_valid, ctx_ready;
  ctx_t               ctx;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      rank_count <= COUNT_W'(2);
      chunk_size <= '0;
    end else if (cfg.valid) begin
      case (cfg.index)
        CFG_RANK_COUNT: rank_count <= cfg.data[COUNT_W-1:0];
        CFG_CHUNK_SIZE: chunk_size <= cfg.data;
        default: begin
          rank_count <= rank_count;
        end
      endcase
    end
  end

  ahds_front #(
    .MAX_RANKS (MAX_RANKS)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .req        (req),
    .rank_count (rank_count),
    .chunk_size (chunk_size),
    .ctx_valid  (ctx_valid),
    .ctx_ready  (ctx_ready),
    .ctx        (ctx)
  );

  ahds_seq u_seq (
    .clk       (clk),
    .rst       (rst),
    .ctx_valid (ctx_valid),
    .ctx_ready (ctx_ready),
    .ctx       (ctx),
    .steps     (steps)
  );

  a_next_index: assert property (@(posedge clk) disable iff (rst)
    (steps.valid && steps.ready && !steps.last) |=>
      (steps.valid && steps.step_index == $past(steps.step_index) + STEP_W'(1)))
    else $error("step index did not advance within a schedule");

  a_idle_bytes: assert property (@(posedge clk) disable iff (rst)
    (steps.valid && !steps.send_valid) |-> (steps.byte_count == '0))
    else $error("byte count on a step without a send");

  a_index_range: assert property (@(posedge clk) disable iff (rst)
    steps.valid |-> (steps.step_index <= STEP_W'(20)))
    else $error("step index beyond longest schedule");

endmodule

/* design/ahds_front.sv */
// ----------------------------------------------------------------------------
// ahds_front
// Three-stage request pipeline: clamp the rank count, derive the power of
// two, remainder and transfer total, then fold the rank into its context.
// ----------------------------------------------------------------------------
module ahds_front import ahds_pkg::*; #(
  parameter int unsigned MAX_RANKS = MAX_RANKS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  ahds_req_if.sink           req,
  input  logic [COUNT_W-1:0] rank_count,
  input  logic [CHUNK_W-1:0] chunk_size,
  output logic               ctx_valid,
  input  logic               ctx_ready,
  output ctx_t               ctx
);

  localparam int unsigned PMAX = (MAX_RANKS > 2047) ? 2047 : MAX_RANKS;
  localparam logic [COUNT_W-1:0] P_MAX = COUNT_W'(PMAX);
  localparam logic [COUNT_W-1:0] P_MIN = COUNT_W'(2);

  logic               v1, v2, v3;
  logic               rdy1, rdy2, rdy3;
  logic [RANK_W-1:0]  rank1, rank2;
  logic [COUNT_W-1:0] p1, p_clamp;
  logic [COUNT_W-1:0] pw;
  logic [LG_W-1:0]    lg;
  logic [LG_W-1:0]    lg2;
  logic [RANK_W-1:0]  r2;
  logic [TOTAL_W-1:0] total2;
  logic               low;
  logic [RANK_W-1:0]  q;

  assign rdy3 = !v3 || ctx_ready;
  assign rdy2 = !v2 || rdy3;
  assign rdy1 = !v1 || rdy2;
  assign req.ready = rdy1;

  always_comb begin
    if (rank_count < P_MIN) begin
      p_clamp = P_MIN;
    end else if (rank_count > P_MAX) begin
      p_clamp = P_MAX;
    end else begin
      p_clamp = rank_count;
    end
  end

  always_comb begin
    lg = '0;
    for (int i = 0; i < COUNT_W; i++) begin
      if (p1[i]) begin
        lg = LG_W'(i);
      end
    end
    pw = COUNT_W'(1) << lg;
  end

  always_comb begin
    low = {1'b0, rank2} < {r2, 1'b0};
    if (low) begin
      q = rank2[0] ? '0 : (rank2 >> 1);
    end else begin
      q = rank2 - r2;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      if (rdy1) begin
        v1 <= req.valid;
      end
      if (rdy2) begin
        v2 <= v1 && ({1'b0, rank1} < p1);
      end
      if (rdy3) begin
        v3 <= v2;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rdy1) begin
      rank1 <= req.rank;
      p1    <= p_clamp;
    end
    if (rdy2) begin
      rank2  <= rank1;
      lg2    <= lg;
      r2     <= RANK_W'(p1 - pw);
      total2 <= TOTAL_W'(chunk_size) * TOTAL_W'(p1);
    end
    if (rdy3) begin
      ctx.rank  <= rank2;
      ctx.q     <= q;
      ctx.sit   <= low && rank2[0];
      ctx.low   <= low;
      ctx.fold  <= r2 != '0;
      ctx.lg    <= lg2;
      ctx.r     <= r2;
      ctx.total <= total2;
    end
  end

  assign ctx_valid = v3;

endmodule

/* design/ahds_seq.sv */
// ----------------------------------------------------------------------------
// ahds_seq
// Step sequencer: walks fold, halving, doubling and unfold phases of one
// context, one step per unstalled cycle, into a registered output stage.
// ----------------------------------------------------------------------------
module ahds_seq import ahds_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       ctx_valid,
  output logic       ctx_ready,
  input  ctx_t       ctx,
  ahds_step_if.source steps
);

  phase_t            phase, phase_next;
  logic [LG_W-1:0]   e, e_next;
  logic [STEP_W-1:0] k, k_next;
  ctx_t              cur;

  logic              gen_ready, fire, take, is_last;
  logic              rv, sv;
  logic [RANK_W-1:0] rp, sp;
  logic [TOTAL_W-1:0] bytes;
  logic [RANK_W-1:0] xq, buddy, peer;
  logic [COUNT_W-1:0] peer_w;

  assign gen_ready = !steps.valid || steps.ready;
  assign fire      = (phase != PH_IDLE) && gen_ready;
  assign is_last   = (phase == PH_UNFOLD) ||
                     ((phase == PH_DOUBLE) && (e == '0) && !cur.fold);
  assign take      = ctx_valid && ((phase == PH_IDLE) || (fire && is_last));
  assign ctx_ready = take;

  always_comb begin
    phase_next = phase;
    e_next     = e;
    k_next     = k;
    if (take) begin
      phase_next = ctx.fold ? PH_FOLD_X : PH_HALVE;
      e_next     = '0;
      k_next     = '0;
    end else if (fire) begin
      k_next = k + STEP_W'(1);
      case (phase)
        PH_FOLD_X: phase_next = PH_FOLD_Y;
        PH_FOLD_Y: phase_next = PH_HALVE;
        PH_HALVE: begin
          if ((e + LG_W'(1)) == cur.lg) begin
            phase_next = PH_DOUBLE;
          end else begin
            e_next = e + LG_W'(1);
          end
        end
        PH_DOUBLE: begin
          if (e == '0) begin
            phase_next = cur.fold ? PH_UNFOLD : PH_IDLE;
          end else begin
            e_next = e - LG_W'(1);
          end
        end
        PH_UNFOLD: phase_next = PH_IDLE;
        default:   phase_next = PH_IDLE;
      endcase
    end
  end

  always_comb begin
    buddy  = cur.rank ^ RANK_W'(1);
    xq     = cur.q ^ (RANK_W'(1) << e);
    peer_w = (xq < cur.r) ? {xq, 1'b0} : ({1'b0, xq} + {1'b0, cur.r});
    peer   = peer_w[RANK_W-1:0];
    rv     = 1'b0;
    sv     = 1'b0;
    rp     = '0;
    sp     = '0;
    bytes  = '0;
    case (phase)
      PH_FOLD_X: begin
        if (cur.low) begin
          rv    = 1'b1;
          sv    = 1'b1;
          rp    = buddy;
          sp    = buddy;
          bytes = cur.total >> 1;
        end
      end
      PH_FOLD_Y: begin
        if (cur.low && cur.rank[0]) begin
          sv    = 1'b1;
          sp    = buddy;
          bytes = cur.total >> 1;
        end else if (cur.low) begin
          rv = 1'b1;
          rp = buddy;
        end
      end
      PH_HALVE, PH_DOUBLE: begin
        if (!cur.sit) begin
          rv    = 1'b1;
          sv    = 1'b1;
          rp    = peer;
          sp    = peer;
          bytes = cur.total >> ({1'b0, e} + 5'd1);
        end
      end
      PH_UNFOLD: begin
        if (cur.low && cur.rank[0]) begin
          rv = 1'b1;
          rp = buddy;
        end else if (cur.low) begin
          sv    = 1'b1;
          sp    = buddy;
          bytes = cur.total;
        end
      end
      default: begin
        rv = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_IDLE;
      steps.valid <= 1'b0;
    end else begin
      phase <= phase_next;
      if (gen_ready) begin
        steps.valid <= fire;
      end
    end
  end

  always_ff @(posedge clk) begin
    e <= e_next;
    k <= k_next;
    if (take) begin
      cur <= ctx;
    end
    if (fire) begin
      steps.step_index <= k;
      steps.recv_valid <= rv;
      steps.recv_peer  <= rp;
      steps.send_valid <= sv;
      steps.send_peer  <= sp;
      steps.byte_count <= bytes[BYTES_W-1:0];
      steps.last       <= is_last;
    end
  end

endmodule
